>>> rtl/core/lfu_page_replacement_assert.svh
// ----------------------------------------------------------------------------
// LFU page replacement assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef LFU_PAGE_REPLACEMENT_ASSERT_SVH
`define LFU_PAGE_REPLACEMENT_ASSERT_SVH

// same-cycle implication
`define LFU_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lfu_page_replacement: same-cycle check failed");

// next-cycle implication
`define LFU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lfu_page_replacement: next-cycle check failed");

`endif

>>> rtl/core/lfu_pkg.sv
// ----------------------------------------------------------------------------
// LFU page replacement package
// Sizes, constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package lfu_pkg;

   localparam int FRAMES     = 16;
   localparam int PAGE_BITS  = 16;
   localparam int COUNT_BITS = 16;
   localparam int FAULT_BITS = 32;
   localparam int CFG_BITS   = 5;

   localparam int SLOT_BITS = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int RANK_BITS = SLOT_BITS;
   localparam int RES_BITS  = $clog2(FRAMES + 1);

   localparam logic [CFG_BITS-1:0]  CFG_RESET = CFG_BITS'(16);
   localparam logic [SLOT_BITS-1:0] LAST_IDX  = SLOT_BITS'(FRAMES - 1);

   typedef struct packed {
      logic                 load;
      logic                 scan_en;
      logic [SLOT_BITS-1:0] scan_idx;
      logic                 commit;
   } lfu_cmd_type;

   typedef struct packed {
      logic out_busy;
   } lfu_status_type;

endpackage

>>> rtl/core/lfu_ctrl.sv
// ----------------------------------------------------------------------------
// LFU controller
// Sequences accept, slot scan and commit for one reference at a time.
// ----------------------------------------------------------------------------
module lfu_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  lfu_pkg::lfu_status_type status,
   output lfu_pkg::lfu_cmd_type    cmd
);
   import lfu_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   state_type            state_ff;
   logic [SLOT_BITS-1:0] idx_ff;
   logic                 stall_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         stall_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_SCAN;
                  idx_ff   <= '0;
                  stall_ff <= 1'b1;
               end
            end
            ST_SCAN: begin
               if (idx_ff == LAST_IDX) begin
                  state_ff <= ST_COMMIT;
               end else begin
                  idx_ff <= idx_ff + SLOT_BITS'(1);
               end
            end
            ST_COMMIT: begin
               // hold until the result register can take the new beat
               if (!status.out_busy) begin
                  state_ff <= ST_IDLE;
                  stall_ff <= 1'b0;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               stall_ff <= 1'b0;
            end
         endcase
      end
   end

   assign req_stall = stall_ff;

   always_comb begin
      cmd          = '0;
      cmd.scan_idx = idx_ff;
      cmd.load     = (state_ff == ST_IDLE) && req_valid;
      cmd.scan_en  = (state_ff == ST_SCAN);
      cmd.commit   = (state_ff == ST_COMMIT) && !status.out_busy;
   end

endmodule

>>> rtl/core/lfu_dp.sv
// ----------------------------------------------------------------------------
// LFU datapath
// Slot table, scan trackers, table update and result register.
// ----------------------------------------------------------------------------
module lfu_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  lfu_pkg::lfu_cmd_type            cmd,
   output lfu_pkg::lfu_status_type         status,
   input  logic                            csr_wr,
   input  logic [lfu_pkg::CFG_BITS-1:0]    csr_data,
   input  logic [lfu_pkg::PAGE_BITS-1:0]   req_page_number,
   input  logic                            req_last_in_string,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_was_fault,
   output logic                            rsp_evicted_valid,
   output logic [lfu_pkg::PAGE_BITS-1:0]   rsp_evicted_page,
   output logic [lfu_pkg::FAULT_BITS-1:0]  rsp_fault_count
);
   import lfu_pkg::*;

   // slot table
   logic [FRAMES-1:0]     valid_ff, valid_in;
   logic [PAGE_BITS-1:0]  page_ff  [FRAMES];
   logic [COUNT_BITS-1:0] count_ff [FRAMES];
   logic [RANK_BITS-1:0]  rank_ff  [FRAMES];
   logic [RANK_BITS-1:0]  rank_in  [FRAMES];
   logic [RES_BITS-1:0]   resident_ff, resident_in;
   logic [FAULT_BITS-1:0] fault_total_ff, fault_total_in;
   logic [CFG_BITS-1:0]   frames_ff;

   // captured request
   logic [PAGE_BITS-1:0]  req_page_ff;
   logic                  req_last_ff;

   // scan trackers
   logic                  hit_found_ff;
   logic [SLOT_BITS-1:0]  hit_idx_ff;
   logic [COUNT_BITS-1:0] hit_count_ff;
   logic [RANK_BITS-1:0]  hit_rank_ff;
   logic                  best_have_ff;
   logic [SLOT_BITS-1:0]  best_idx_ff;
   logic [COUNT_BITS-1:0] best_count_ff;
   logic [RANK_BITS-1:0]  best_rank_ff;
   logic [PAGE_BITS-1:0]  best_page_ff;
   logic                  free_found_ff;
   logic [SLOT_BITS-1:0]  free_idx_ff;

   // result register
   logic                  out_valid_ff;
   logic                  out_fault_ff;
   logic                  out_ev_valid_ff;
   logic [PAGE_BITS-1:0]  out_ev_page_ff;
   logic [FAULT_BITS-1:0] out_count_ff;

   // scan read
   logic                  cur_valid;
   logic [PAGE_BITS-1:0]  cur_page;
   logic [COUNT_BITS-1:0] cur_count;
   logic [RANK_BITS-1:0]  cur_rank;
   logic                  cur_hit;
   logic                  cur_better;

   // commit decision
   logic [31:0]           cap_w;
   logic                  need_evict;
   logic                  age_all;
   logic [SLOT_BITS-1:0]  target_idx;
   logic [RANK_BITS-1:0]  limit_rank;
   logic [COUNT_BITS-1:0] target_count;
   logic                  was_fault;

   assign cur_valid = valid_ff[cmd.scan_idx];
   assign cur_page  = page_ff[cmd.scan_idx];
   assign cur_count = count_ff[cmd.scan_idx];
   assign cur_rank  = rank_ff[cmd.scan_idx];
   assign cur_hit   = cur_valid && (cur_page == req_page_ff);
   // lower count wins; on equal counts the older (larger rank) wins
   assign cur_better = cur_valid && (!best_have_ff || (cur_count < best_count_ff) ||
                       ((cur_count == best_count_ff) && (cur_rank > best_rank_ff)));

   always_comb begin
      cap_w = 32'(frames_ff);
      if (cap_w == 32'd0) begin
         cap_w = 32'd1;
      end else if (cap_w > 32'(FRAMES)) begin
         cap_w = 32'(FRAMES);
      end
   end

   assign was_fault  = !hit_found_ff;
   assign need_evict = was_fault && (32'(resident_ff) >= cap_w);
   assign age_all    = was_fault && !need_evict;
   assign limit_rank = hit_found_ff ? hit_rank_ff : best_rank_ff;

   always_comb begin
      if (hit_found_ff) begin
         target_idx = hit_idx_ff;
      end else if (need_evict) begin
         target_idx = best_idx_ff;
      end else begin
         target_idx = free_idx_ff;
      end
   end

   always_comb begin
      if (!hit_found_ff) begin
         target_count = COUNT_BITS'(1);
      end else if (&hit_count_ff) begin
         target_count = hit_count_ff;
      end else begin
         target_count = hit_count_ff + COUNT_BITS'(1);
      end
   end

   // Eviction then aging of all slots nets out to aging only the slots
   // younger than the victim, so hit and evict share one limit.
   always_comb begin
      for (int i = 0; i < FRAMES; i++) begin
         rank_in[i] = rank_ff[i];
         if (SLOT_BITS'(i) == target_idx) begin
            rank_in[i] = '0;
         end else if (valid_ff[i] && (age_all || (rank_ff[i] < limit_rank))) begin
            rank_in[i] = rank_ff[i] + RANK_BITS'(1);
         end
      end
   end

   always_comb begin
      valid_in       = valid_ff;
      resident_in    = resident_ff;
      fault_total_in = fault_total_ff;
      valid_in[target_idx] = 1'b1;
      if (age_all) begin
         resident_in = resident_ff + RES_BITS'(1);
      end
      if (was_fault && !(&fault_total_ff)) begin
         fault_total_in = fault_total_ff + FAULT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= '0;
         resident_ff    <= '0;
         fault_total_ff <= '0;
         frames_ff      <= CFG_RESET;
         hit_found_ff   <= 1'b0;
         best_have_ff   <= 1'b0;
         free_found_ff  <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr) begin
            frames_ff <= csr_data;
         end

         if (cmd.load) begin
            hit_found_ff  <= 1'b0;
            best_have_ff  <= 1'b0;
            free_found_ff <= 1'b0;
         end else if (cmd.scan_en) begin
            if (cur_hit && !hit_found_ff) begin
               hit_found_ff <= 1'b1;
            end
            if (cur_better) begin
               best_have_ff <= 1'b1;
            end
            if (!cur_valid && !free_found_ff) begin
               free_found_ff <= 1'b1;
            end
         end

         if (cmd.commit) begin
            out_valid_ff <= 1'b1;
            if (req_last_ff) begin
               // end of string: table and fault total start over
               valid_ff       <= '0;
               resident_ff    <= '0;
               fault_total_ff <= '0;
            end else begin
               valid_ff       <= valid_in;
               resident_ff    <= resident_in;
               fault_total_ff <= fault_total_in;
            end
         end else if (out_valid_ff && !rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_page_ff <= req_page_number;
         req_last_ff <= req_last_in_string;
      end

      if (cmd.scan_en) begin
         if (cur_hit && !hit_found_ff) begin
            hit_idx_ff   <= cmd.scan_idx;
            hit_count_ff <= cur_count;
            hit_rank_ff  <= cur_rank;
         end
         if (cur_better) begin
            best_idx_ff   <= cmd.scan_idx;
            best_count_ff <= cur_count;
            best_rank_ff  <= cur_rank;
            best_page_ff  <= cur_page;
         end
         if (!cur_valid && !free_found_ff) begin
            free_idx_ff <= cmd.scan_idx;
         end
      end

      if (cmd.commit) begin
         page_ff[target_idx]  <= req_page_ff;
         count_ff[target_idx] <= target_count;
         for (int i = 0; i < FRAMES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
         out_fault_ff    <= was_fault;
         out_ev_valid_ff <= need_evict;
         out_ev_page_ff  <= need_evict ? best_page_ff : '0;
         out_count_ff    <= fault_total_in;
      end
   end

   assign status.out_busy   = out_valid_ff && rsp_stall;
   assign rsp_valid         = out_valid_ff;
   assign rsp_was_fault     = out_fault_ff;
   assign rsp_evicted_valid = out_ev_valid_ff;
   assign rsp_evicted_page  = out_ev_page_ff;
   assign rsp_fault_count   = out_count_ff;

endmodule

>>> rtl/core/lfu_page_replacement.sv
// ----------------------------------------------------------------------------
// LFU page replacement
// Least-frequently-used page table with least-recently-used tie-break.
// ----------------------------------------------------------------------------
// Per page reference, the controller accepts the beat, then walks all 16
// frames of the slot table through a single read port, doing the tag match
// and the lowest-count/oldest victim search together, and then updates the
// table and loads the result register. The result register lets the next
// reference be accepted while a result still waits; that reference's update
// holds until the waiting result is taken. The frame-count register accepts a
// write in every cycle and should only be written while the block is idle.
module lfu_page_replacement (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [lfu_pkg::CFG_BITS-1:0]    csr_frames_in_use,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [lfu_pkg::PAGE_BITS-1:0]   req_page_number,
   input  logic                            req_last_in_string,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_was_fault,
   output logic                            rsp_evicted_valid,
   output logic [lfu_pkg::PAGE_BITS-1:0]   rsp_evicted_page,
   output logic [lfu_pkg::FAULT_BITS-1:0]  rsp_fault_count
);
   import lfu_pkg::*;

   lfu_cmd_type    cmd;
   lfu_status_type status;

   assign csr_ready = 1'b1;

   lfu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lfu_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_wr             (csr_valid && csr_ready),
      .csr_data           (csr_frames_in_use),
      .req_page_number    (req_page_number),
      .req_last_in_string (req_last_in_string),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_was_fault      (rsp_was_fault),
      .rsp_evicted_valid  (rsp_evicted_valid),
      .rsp_evicted_page   (rsp_evicted_page),
      .rsp_fault_count    (rsp_fault_count)
   );

endmodule

>>> rtl/core/lfu_chk.sv
// ----------------------------------------------------------------------------
// LFU page replacement checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "lfu_page_replacement_assert.svh"

module lfu_chk (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic                            rsp_was_fault,
   input logic                            rsp_evicted_valid,
   input logic [lfu_pkg::PAGE_BITS-1:0]   rsp_evicted_page,
   input logic [lfu_pkg::FAULT_BITS-1:0]  rsp_fault_count
);

   // a reference in flight blocks the next beat
   `LFU_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   // eviction only happens on a fault
   `LFU_ASSERT_IMPLY(a_evict_needs_fault, clock, reset, rsp_valid && rsp_evicted_valid, rsp_was_fault)

   // evicted page reads zero when nothing was evicted
   `LFU_ASSERT_IMPLY(a_evict_page_zero, clock, reset, rsp_valid && !rsp_evicted_valid, rsp_evicted_page == '0)

   // a fault always counts, so the total is nonzero with a fault result
   `LFU_ASSERT_IMPLY(a_fault_counted, clock, reset, rsp_valid && rsp_was_fault, rsp_fault_count != '0)

   `LFU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_fault_count))

endmodule

bind lfu_page_replacement lfu_chk u_lfu_chk (.*);
